FILE: rtl/assert_macros.svh
// Assertion macros shared by the timer RTL.
// Depends on nothing; synthesis builds define SYNTH to drop the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SCT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("timer assertion failed");
`define SCT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timer assertion failed");
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timer assertion failed");
`else
`define SCT_ASSERT(label, clk, rst, prop)
`define SCT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SCT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/sctmr_pkg.sv
// Package for the six-channel reload down timer: sizes, codes and the prescale mask table.
// Depends on nothing; used by the timer top level.
`timescale 1ns / 1ps

package sctmr_pkg;

   localparam int CHANNELS    = 6;
   localparam int COUNT_WIDTH = 32;
   localparam int PRE_WIDTH   = 10;
   localparam int GROUP_SIZE  = 3;
   localparam int DATA_WIDTH  = 32;
   localparam int SEL_WIDTH   = 3;
   localparam int CH_WIDTH    = 3;

   localparam int CTRL_ENABLE_BIT = 3;
   localparam int CTRL_FLAG_BIT   = 4;
   localparam logic [SEL_WIDTH-1:0] SEL_MAX = 3'd4;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      REG_COUNT  = 2'd0,
      REG_RELOAD = 2'd1,
      REG_CTRL   = 2'd2,
      REG_START  = 2'd3
   } reg_sel_type;

   function automatic logic [PRE_WIDTH-1:0] prescale_mask(input logic [SEL_WIDTH-1:0] sel);
      logic [PRE_WIDTH-1:0] mask;
      case (sel)
         3'd0: mask = 10'h003;
         3'd1: mask = 10'h00F;
         3'd2: mask = 10'h03F;
         3'd3: mask = 10'h0FF;
         3'd4: mask = 10'h3FF;
         default: mask = '0;
      endcase
      return mask;
   endfunction

endpackage

FILE: rtl/six_channel_reload_down_timer_top.sv
// Six-channel reload down timer. Bus reads, bus writes and peripheral clock ticks all arrive
// as beats on one request stream, and every beat yields exactly one response beat carrying
// the read data and the interrupt and running masks as they stand after that beat. A beat
// passes through an input register and executes when the output register can take its result;
// a new beat is taken every cycle while the response stream does not stall. All six channels
// and the shared 10-bit prescaler update in parallel when a beat executes, and only a stalled
// response stream slows the block down.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module six_channel_reload_down_timer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: op[1:0], channel[4:2], reg_sel[6:5], wdata[38:7], zero pad.
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: read_data[31:0], irq_lines[37:32], running_mask[43:38], zero pad.
   output logic [47:0] rsp_tdata
);

   localparam int CW = sctmr_pkg::COUNT_WIDTH;
   localparam int NC = sctmr_pkg::CHANNELS;

   logic                                  in_valid_ff;
   logic [1:0]                            in_op_ff;
   logic [sctmr_pkg::CH_WIDTH-1:0]        in_ch_ff;
   logic [1:0]                            in_rs_ff;
   logic [sctmr_pkg::DATA_WIDTH-1:0]      in_wd_ff;

   logic                                  out_valid_ff;
   logic [sctmr_pkg::DATA_WIDTH-1:0]      out_rd_ff;
   logic [5:0]                            out_irq_ff;
   logic [5:0]                            out_run_ff;

   logic [CW-1:0]                         count_ff  [NC];
   logic [CW-1:0]                         count_in  [NC];
   logic [CW-1:0]                         reload_ff [NC];
   logic [CW-1:0]                         reload_in [NC];
   logic [sctmr_pkg::SEL_WIDTH-1:0]       sel_ff    [NC];
   logic [sctmr_pkg::SEL_WIDTH-1:0]       sel_in    [NC];
   logic [NC-1:0]                         en_ff, en_in;
   logic [NC-1:0]                         flag_ff, flag_in;
   logic [NC-1:0]                         run_ff, run_in;
   logic [sctmr_pkg::PRE_WIDTH-1:0]       pre_ff, pre_in;

   logic                                  execute;
   logic                                  advance;
   logic                                  ch_ok;
   logic                                  hi_group;
   logic [sctmr_pkg::DATA_WIDTH-1:0]      rd_in;
   logic [5:0]                            irq_in;
   logic [5:0]                            runmask_in;

   assign advance    = !out_valid_ff || rsp_tready;
   assign execute    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign ch_ok    = in_ch_ff < sctmr_pkg::CH_WIDTH'(NC);
   assign hi_group = in_ch_ff >= sctmr_pkg::CH_WIDTH'(sctmr_pkg::GROUP_SIZE);

   always_comb begin
      pre_in = pre_ff;
      rd_in  = '0;
      for (int c = 0; c < NC; c++) begin
         count_in[c]  = count_ff[c];
         reload_in[c] = reload_ff[c];
         sel_in[c]    = sel_ff[c];
      end
      en_in   = en_ff;
      flag_in = flag_ff;
      run_in  = run_ff;

      case (in_op_ff)
         sctmr_pkg::OP_TICK: begin
            pre_in = pre_ff + 1'b1;
            for (int c = 0; c < NC; c++) begin
               if (run_ff[c] && (sel_ff[c] <= sctmr_pkg::SEL_MAX)
                   && ((pre_in & sctmr_pkg::prescale_mask(sel_ff[c])) == '0)) begin
                  if (count_ff[c] == '0) begin
                     count_in[c] = reload_ff[c];
                     flag_in[c]  = 1'b1;
                  end else begin
                     count_in[c] = count_ff[c] - 1'b1;
                  end
               end
            end
         end
         sctmr_pkg::OP_READ, sctmr_pkg::OP_WRITE: begin
            for (int c = 0; c < NC; c++) begin
               if (in_rs_ff == sctmr_pkg::REG_START) begin
                  if (ch_ok && (hi_group == (c >= sctmr_pkg::GROUP_SIZE))) begin
                     if (in_op_ff == sctmr_pkg::OP_READ) begin
                        rd_in[c % sctmr_pkg::GROUP_SIZE] = run_ff[c];
                     end else begin
                        run_in[c] = in_wd_ff[c % sctmr_pkg::GROUP_SIZE];
                     end
                  end
               end else if (in_ch_ff == sctmr_pkg::CH_WIDTH'(c)) begin
                  if (in_op_ff == sctmr_pkg::OP_READ) begin
                     case (in_rs_ff)
                        sctmr_pkg::REG_COUNT:  rd_in = sctmr_pkg::DATA_WIDTH'(count_ff[c]);
                        sctmr_pkg::REG_RELOAD: rd_in = sctmr_pkg::DATA_WIDTH'(reload_ff[c]);
                        default: rd_in = sctmr_pkg::DATA_WIDTH'({flag_ff[c], en_ff[c], sel_ff[c]});
                     endcase
                  end else begin
                     case (in_rs_ff)
                        sctmr_pkg::REG_COUNT:  count_in[c]  = in_wd_ff[CW-1:0];
                        sctmr_pkg::REG_RELOAD: reload_in[c] = in_wd_ff[CW-1:0];
                        default: begin
                           sel_in[c] = in_wd_ff[sctmr_pkg::SEL_WIDTH-1:0];
                           en_in[c]  = in_wd_ff[sctmr_pkg::CTRL_ENABLE_BIT];
                           if (!in_wd_ff[sctmr_pkg::CTRL_FLAG_BIT]) begin
                              flag_in[c] = 1'b0;
                           end
                        end
                     endcase
                  end
               end
            end
         end
         default: begin
         end
      endcase

      irq_in     = 6'(flag_in & en_in);
      runmask_in = 6'(run_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pre_ff       <= '0;
         en_ff        <= '0;
         flag_ff      <= '0;
         run_ff       <= '0;
         for (int c = 0; c < NC; c++) begin
            count_ff[c]  <= '1;
            reload_ff[c] <= '1;
            sel_ff[c]    <= '0;
         end
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (execute) begin
            pre_ff  <= pre_in;
            en_ff   <= en_in;
            flag_ff <= flag_in;
            run_ff  <= run_in;
            for (int c = 0; c < NC; c++) begin
               count_ff[c]  <= count_in[c];
               reload_ff[c] <= reload_in[c];
               sel_ff[c]    <= sel_in[c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_op_ff <= req_tdata[1:0];
         in_ch_ff <= req_tdata[4:2];
         in_rs_ff <= req_tdata[6:5];
         in_wd_ff <= req_tdata[38:7];
      end
      if (execute) begin
         out_rd_ff  <= rd_in;
         out_irq_ff <= irq_in;
         out_run_ff <= runmask_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, out_run_ff, out_irq_ff, out_rd_ff};

   `SCT_ASSERT_IMPL(a_irq_matches_state, clock, reset, out_valid_ff,
      out_irq_ff == 6'(flag_ff & en_ff))
   `SCT_ASSERT_IMPL(a_run_matches_state, clock, reset, out_valid_ff,
      out_run_ff == 6'(run_ff))
   `SCT_ASSERT_NEXT(a_prescaler_steps, clock, reset,
      execute && (in_op_ff == sctmr_pkg::OP_TICK), pre_ff == $past(pre_ff) + 1'b1)
   `SCT_ASSERT_NEXT(a_state_holds_when_idle, clock, reset, !execute,
      $stable(pre_ff) && $stable(run_ff) && $stable(flag_ff))
   `SCT_ASSERT_IMPL(a_stall_means_full, clock, reset, !req_tready,
      in_valid_ff && out_valid_ff)

endmodule
